FILE: src/imtb_pkg.sv
// ============================================================================
// imtb_pkg: shared types and constants of the inverse map table builder
// Sizes of the map, the row table and the request operation codes.
// ============================================================================
package imtb_pkg;

   // Largest map that can be loaded, and largest number of coarse rows.
   localparam int unsigned FINE_MAX   = 1024;
   localparam int unsigned COARSE_MAX = 1024;

   // Index widths: a fine entry or a slot, a coarse row, and a count that can
   // hold the maximum itself.
   localparam int unsigned FIW = $clog2(FINE_MAX);
   localparam int unsigned RIW = $clog2(COARSE_MAX);
   localparam int unsigned CW  = $clog2(FINE_MAX + 1);

   // The offset table has one entry more than there are rows.
   localparam int unsigned OFF_DEPTH = COARSE_MAX + 1;
   localparam int unsigned OAW       = $clog2(OFF_DEPTH);

   typedef logic [1:0]    op_type;
   typedef logic [CW-1:0] count_type;

   localparam op_type OP_LOAD     = 2'd0;
   localparam op_type OP_READ_SLOT = 2'd1;
   localparam op_type OP_READ_ROW = 2'd2;

   localparam count_type FINE_MAX_C   = count_type'(FINE_MAX);
   localparam count_type COARSE_MAX_C = count_type'(COARSE_MAX);

endpackage

FILE: src/inverse_map_table_builder_top.sv
// ============================================================================
// inverse_map_table_builder_top: coarse-to-fine inverse table builder
// Loads a fine-to-coarse map, builds its inverse in compressed row form with
// a counting sort, and serves reads of table slots and row start offsets.
// ============================================================================
//
//   Channel | Direction | Ports                                        | Use
//   --------+-----------+----------------------------------------------+-------------------
//   req     | in        | valid, ready, op, coarse_index, is_last,     | load / read
//           |           | position                                     |
//   rsp     | out       | valid, ready, value, owner_row, ok           | read results
//   csr     | in        | valid, ready, coarse_count                   | row count register
//
// A read transaction passes through the response state to its result, which
// sits in an output register; the next request is accepted while that
// result waits for rsp_ready. A load marked last starts the build: a clear
// of rows+1 offset entries (one a cycle), a count pass over the loaded entries
// (CNT_A, CNT_B, CNT_C), a prefix pass over the rows (PFX_A, PFX_B) and a
// scatter pass over the loaded entries (SCT_A, SCT_B, SCT_C). Each pass is
// limited by the single read port of its memory. During the build the request
// channel is not ready; the register port is always ready.
// Reset is synchronous and active high; it empties the map and clears the
// built state. The memories are not cleared: the build clears what it uses.
// ============================================================================
module inverse_map_table_builder_top (
   input  logic                       clock,
   input  logic                       reset,
   // Request channel.
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_op,
   input  logic signed [10:0]         req_coarse_index,
   input  logic                       req_is_last,
   input  logic [10:0]                req_position,
   // Response channel.
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [10:0]                rsp_value,
   output logic [9:0]                 rsp_owner_row,
   output logic                       rsp_ok,
   // Configuration register port.
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [10:0]                csr_coarse_count
);

   // Sequencer states.
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_RESP  = 4'd1;
   localparam logic [3:0] S_CLR   = 4'd2;
   localparam logic [3:0] S_CNT_A = 4'd3;
   localparam logic [3:0] S_CNT_B = 4'd4;
   localparam logic [3:0] S_CNT_C = 4'd5;
   localparam logic [3:0] S_PFX_A = 4'd6;
   localparam logic [3:0] S_PFX_B = 4'd7;
   localparam logic [3:0] S_SCT_A = 4'd8;
   localparam logic [3:0] S_SCT_B = 4'd9;
   localparam logic [3:0] S_SCT_C = 4'd10;

   // Memories. The target store holds the raw coarse index of each fine entry,
   // the offset memory holds counts and then row starts, the cursor memory the
   // next free slot of each row during the scatter.
   logic [10:0]                   tgt_mem [imtb_pkg::FINE_MAX];
   imtb_pkg::count_type           off_mem [imtb_pkg::OFF_DEPTH];
   imtb_pkg::count_type           cur_mem [imtb_pkg::COARSE_MAX];
   logic [imtb_pkg::FIW-1:0]      col_mem [imtb_pkg::FINE_MAX];
   logic [imtb_pkg::RIW-1:0]      row_mem [imtb_pkg::FINE_MAX];

   // Sequencer and bookkeeping registers.
   logic [3:0]                    state_ff, state_in;
   imtb_pkg::count_type           k_ff, k_in;
   imtb_pkg::count_type           r_ff, r_in;
   imtb_pkg::count_type           acc_ff, acc_in;
   imtb_pkg::count_type           v_ff, v_in;
   imtb_pkg::count_type           rows_ff, rows_in;
   imtb_pkg::count_type           total_ff, total_in;
   imtb_pkg::count_type           loaded_ff, loaded_in;
   logic                          built_ff, built_in;
   imtb_pkg::count_type           cfg_ff;
   imtb_pkg::op_type              rd_op_ff;
   imtb_pkg::count_type           rd_pos_ff;

   // Registered memory read data.
   logic [10:0]                   tgt_rd_ff;
   imtb_pkg::count_type           off_rd_ff;
   imtb_pkg::count_type           cur_rd_ff;
   logic [imtb_pkg::FIW-1:0]      col_rd_ff;
   logic [imtb_pkg::RIW-1:0]      row_rd_ff;

   // Output register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [10:0]                   rsp_value_ff;
   logic [9:0]                    rsp_owner_ff;
   logic                          rsp_ok_ff;

   // Memory port controls.
   logic                          tgt_we;
   logic [imtb_pkg::FIW-1:0]      tgt_waddr;
   logic                          off_we, off_re;
   logic [imtb_pkg::OAW-1:0]      off_waddr, off_raddr;
   imtb_pkg::count_type           off_wdata;
   logic                          cur_we;
   logic [imtb_pkg::RIW-1:0]      cur_waddr;
   imtb_pkg::count_type           cur_wdata;
   logic                          col_we;
   logic [imtb_pkg::FIW-1:0]      col_waddr;

   logic                          req_fire;
   logic                          rsp_load;
   logic                          entry_valid;
   imtb_pkg::count_type           lc_base;
   imtb_pkg::count_type           rows_clamped;
   imtb_pkg::count_type           sum;
   logic                          rd_ok;
   logic [10:0]                   rd_value;
   logic [9:0]                    rd_owner;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // A stored coarse index takes part when it is non-negative and below the
   // row count sampled at the build.
   assign entry_valid = !tgt_rd_ff[10] && (tgt_rd_ff < rows_ff);

   // A load after a build starts a new map.
   assign lc_base = built_ff ? '0 : loaded_ff;

   // Row count clamp: zero stays zero, anything above the maximum is clamped.
   assign rows_clamped = (cfg_ff > imtb_pkg::COARSE_MAX_C) ? imtb_pkg::COARSE_MAX_C : cfg_ff;

   assign sum = acc_ff + off_rd_ff;

   // ---------------------------------------------------------------------------
   // Sequencer.
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in  = state_ff;
      k_in      = k_ff;
      r_in      = r_ff;
      acc_in    = acc_ff;
      v_in      = v_ff;
      rows_in   = rows_ff;
      total_in  = total_ff;
      loaded_in = loaded_ff;
      built_in  = built_ff;
      tgt_we    = 1'b0;
      tgt_waddr = lc_base[imtb_pkg::FIW-1:0];
      off_we    = 1'b0;
      off_waddr = r_ff[imtb_pkg::OAW-1:0];
      off_wdata = '0;
      off_re    = 1'b0;
      off_raddr = req_position[imtb_pkg::OAW-1:0];
      cur_we    = 1'b0;
      cur_waddr = r_ff[imtb_pkg::RIW-1:0];
      cur_wdata = sum;
      col_we    = 1'b0;
      col_waddr = cur_rd_ff[imtb_pkg::FIW-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_op)
                  imtb_pkg::OP_LOAD: begin
                     built_in  = 1'b0;
                     loaded_in = lc_base;
                     // Entries beyond the map size are dropped.
                     if (lc_base < imtb_pkg::FINE_MAX_C) begin
                        tgt_we    = 1'b1;
                        loaded_in = lc_base + 1'b1;
                     end
                     if (req_is_last) begin
                        rows_in  = rows_clamped;
                        r_in     = '0;
                        state_in = S_CLR;
                     end
                  end
                  imtb_pkg::OP_READ_SLOT, imtb_pkg::OP_READ_ROW: begin
                     off_re   = 1'b1;
                     state_in = S_RESP;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_RESP: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         S_CLR: begin
            off_we = 1'b1;
            if (r_ff == rows_ff) begin
               k_in     = '0;
               state_in = S_CNT_A;
            end else begin
               r_in = r_ff + 1'b1;
            end
         end
         S_CNT_A: begin
            if (k_ff == loaded_ff) begin
               // Row zero always starts at slot zero.
               cur_we    = 1'b1;
               cur_waddr = '0;
               cur_wdata = '0;
               acc_in    = '0;
               r_in      = count_type_one();
               state_in  = S_PFX_A;
            end else begin
               state_in = S_CNT_B;
            end
         end
         S_CNT_B: begin
            if (entry_valid) begin
               off_re    = 1'b1;
               off_raddr = imtb_pkg::OAW'(tgt_rd_ff + 11'd1);
               v_in      = tgt_rd_ff + 11'd1;
               state_in  = S_CNT_C;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = S_CNT_A;
            end
         end
         S_CNT_C: begin
            off_we    = 1'b1;
            off_waddr = v_ff[imtb_pkg::OAW-1:0];
            off_wdata = off_rd_ff + 1'b1;
            k_in      = k_ff + 1'b1;
            state_in  = S_CNT_A;
         end
         S_PFX_A: begin
            if (r_ff > rows_ff) begin
               total_in = acc_ff;
               k_in     = '0;
               state_in = S_SCT_A;
            end else begin
               off_re    = 1'b1;
               off_raddr = r_ff[imtb_pkg::OAW-1:0];
               state_in  = S_PFX_B;
            end
         end
         S_PFX_B: begin
            off_we    = 1'b1;
            off_wdata = sum;
            acc_in    = sum;
            cur_we    = (r_ff < rows_ff);
            r_in      = r_ff + 1'b1;
            state_in  = S_PFX_A;
         end
         S_SCT_A: begin
            if (k_ff == loaded_ff) begin
               built_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_SCT_B;
            end
         end
         S_SCT_B: begin
            if (entry_valid) begin
               v_in     = tgt_rd_ff;
               state_in = S_SCT_C;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = S_SCT_A;
            end
         end
         S_SCT_C: begin
            col_we    = (cur_rd_ff < imtb_pkg::FINE_MAX_C);
            cur_we    = 1'b1;
            cur_waddr = v_ff[imtb_pkg::RIW-1:0];
            cur_wdata = cur_rd_ff + 1'b1;
            k_in      = k_ff + 1'b1;
            state_in  = S_SCT_A;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   function automatic imtb_pkg::count_type count_type_one();
      return imtb_pkg::count_type'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rows_ff   <= '0;
         total_ff  <= '0;
         loaded_ff <= '0;
         built_ff  <= 1'b0;
         cfg_ff    <= imtb_pkg::COARSE_MAX_C;
      end else begin
         state_ff  <= state_in;
         rows_ff   <= rows_in;
         total_ff  <= total_in;
         loaded_ff <= loaded_in;
         built_ff  <= built_in;
         if (csr_valid && csr_ready) begin
            cfg_ff <= csr_coarse_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff   <= k_in;
      r_ff   <= r_in;
      acc_ff <= acc_in;
      v_ff   <= v_in;
      if (req_fire) begin
         rd_op_ff  <= req_op;
         rd_pos_ff <= req_position;
      end
   end

   // ---------------------------------------------------------------------------
   // Memories: one write and one registered read each.
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (tgt_we) begin
         tgt_mem[tgt_waddr] <= $unsigned(req_coarse_index);
      end
      tgt_rd_ff <= tgt_mem[k_ff[imtb_pkg::FIW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (off_we) begin
         off_mem[off_waddr] <= off_wdata;
      end
      if (off_re) begin
         off_rd_ff <= off_mem[off_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cur_we) begin
         cur_mem[cur_waddr] <= cur_wdata;
      end
      cur_rd_ff <= cur_mem[tgt_rd_ff[imtb_pkg::RIW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (col_we) begin
         col_mem[col_waddr] <= k_ff[imtb_pkg::FIW-1:0];
         row_mem[col_waddr] <= v_ff[imtb_pkg::RIW-1:0];
      end
      if (req_fire) begin
         col_rd_ff <= col_mem[req_position[imtb_pkg::FIW-1:0]];
         row_rd_ff <= row_mem[req_position[imtb_pkg::FIW-1:0]];
      end
   end

   // ---------------------------------------------------------------------------
   // Read result. A slot lies inside the table when it is below the total
   // entry count; a row number may go up to the row count itself.
   // ---------------------------------------------------------------------------
   always_comb begin
      rd_ok    = 1'b0;
      rd_value = '0;
      rd_owner = '0;
      if (rd_op_ff == imtb_pkg::OP_READ_SLOT) begin
         rd_ok = built_ff && (rd_pos_ff < total_ff);
         if (rd_ok) begin
            rd_value = 11'(col_rd_ff);
            rd_owner = 10'(row_rd_ff);
         end
      end else begin
         rd_ok = built_ff && (rd_pos_ff <= rows_ff);
         if (rd_ok) begin
            rd_value = off_rd_ff;
         end
      end
   end

   assign rsp_load     = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_value_ff <= rd_value;
         rsp_owner_ff <= rd_owner;
         rsp_ok_ff    <= rd_ok;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_owner_row = rsp_owner_ff;
   assign rsp_ok        = rsp_ok_ff;

   // ---------------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------------

   // A built table never lists more entries than were loaded.
   a_total_bounded: assert property (@(posedge clock) disable iff (reset)
      built_ff |-> (total_ff <= loaded_ff))
      else $error("table total exceeds loaded entry count");

   // Every scattered slot lies below the total computed by the prefix pass.
   a_slot_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCT_C) |-> (cur_rd_ff < total_ff))
      else $error("scatter slot outside the table");

   // The running prefix sum cannot pass the number of loaded entries.
   a_prefix_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PFX_A || state_ff == S_PFX_B) |-> (acc_ff <= loaded_ff))
      else $error("prefix sum exceeds loaded entry count");

   // A result outside the table carries zero fields.
   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ok_ff) |-> (rsp_value_ff == '0 && rsp_owner_ff == '0))
      else $error("result outside the table has nonzero fields");

   // A result is loaded only out of the response state, once per read.
   a_resp_leaves: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (state_ff == S_IDLE))
      else $error("sequencer stayed in response state after loading a result");

endmodule
